// ===== rtl/sflr_pkg.sv =====
`timescale 1ns / 1ps

package sflr_pkg;

    // Ring geometry.
    localparam int FIFO_DEPTH = 4096;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;
    localparam int PHASE_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = PHASE_W - FRAC_W;
    localparam int WHOLE_W  = POS_W + 1;
    localparam int STEP_W   = 24;
    localparam int QCNT_W   = 13;
    localparam int UCNT_W   = 32;
    localparam int TCNT_W   = 32;
    localparam int PCNT_W   = 40;
    localparam int PROD_W   = 2 * (SAMPLE_W + 1);

    // Decoupling queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_MIX   = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ENABLED = 2'd0,
        REG_PAUSED  = 2'd1,
        REG_STEP    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic              enabled;
        logic              paused;
        logic [STEP_W-1:0] step_ratio;
    } cfg_t;

    // Everything the back part needs, decided by the front part.
    typedef struct packed {
        logic                       lerp;
        logic                       accepted;
        logic                       underrun;
        logic [FRAC_W-1:0]          frac;
        logic signed [SAMPLE_W-1:0] mix_l;
        logic signed [SAMPLE_W-1:0] mix_r;
        logic [QCNT_W-1:0]          queued_count;
        logic [UCNT_W-1:0]          underrun_total;
        logic [TCNT_W-1:0]          ticks_total;
        logic [PCNT_W-1:0]          pushed_total;
    } info_t;

    typedef struct packed {
        info_t              info;
        logic [FRAME_W-1:0] frame_a;
        logic [FRAME_W-1:0] frame_b;
    } rec_t;

endpackage

// ===== rtl/sflr_if.sv =====
`timescale 1ns / 1ps

interface sflr_in_if import sflr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] push_left;
    logic signed [SAMPLE_W-1:0] push_right;
    logic signed [SAMPLE_W-1:0] mix_in_left;
    logic signed [SAMPLE_W-1:0] mix_in_right;

    modport source (
        output valid, cmd, push_left, push_right, mix_in_left, mix_in_right,
        input  ready
    );
    modport sink (
        input  valid, cmd, push_left, push_right, mix_in_left, mix_in_right,
        output ready
    );
endinterface

interface sflr_out_if import sflr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] mixed_left;
    logic signed [SAMPLE_W-1:0] mixed_right;
    logic                       underrun;
    logic [QCNT_W-1:0]          queued_count;
    logic [UCNT_W-1:0]          underrun_total;
    logic [TCNT_W-1:0]          ticks_total;
    logic [PCNT_W-1:0]          pushed_total;

    modport source (
        output valid, accepted, mixed_left, mixed_right, underrun, queued_count,
               underrun_total, ticks_total, pushed_total,
        input  ready
    );
    modport sink (
        input  valid, accepted, mixed_left, mixed_right, underrun, queued_count,
               underrun_total, ticks_total, pushed_total,
        output ready
    );
endinterface

// ===== rtl/sflr_cfg.sv =====
`timescale 1ns / 1ps

module sflr_cfg import sflr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_ENABLED: cfg_next.enabled    = pwdata[0];
                REG_PAUSED:  cfg_next.paused     = pwdata[0];
                REG_STEP:    cfg_next.step_ratio = pwdata[STEP_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ENABLED: prdata = APB_DATA_W'(cfg_reg.enabled);
            REG_PAUSED:  prdata = APB_DATA_W'(cfg_reg.paused);
            REG_STEP:    prdata = APB_DATA_W'(cfg_reg.step_ratio);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled    <= 1'b0;
            cfg_reg.paused     <= 1'b1;
            cfg_reg.step_ratio <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/sflr_front.sv =====
`timescale 1ns / 1ps

module sflr_front import sflr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    sflr_in_if.sink   in_ch,
    output logic      q_valid,
    input  logic      q_ready,
    output rec_t      q_data
);

    localparam int MW = (CNT_W > WHOLE_W) ? CNT_W : WHOLE_W;
    localparam int SW = MW + 1;

    logic [FRAME_W-1:0] frame_ring [FIFO_DEPTH];

    logic [ADDR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [UCNT_W-1:0]  under_reg, under_next;
    logic [TCNT_W-1:0]  tick_reg, tick_next;
    logic [PCNT_W-1:0]  push_reg, push_next;
    logic               s1_valid_reg;
    info_t              info_reg;
    info_t              info_next;
    logic [FRAME_W-1:0] frame_a_reg, frame_b_reg;

    logic               accept;
    logic               push_ok;
    logic               active;
    logic [MW-1:0]      pos_x, nxt_x, count_x, whole_x, used_x;
    logic               under_hit;
    logic [ADDR_W-1:0]  addr_a, addr_b, slot;
    logic [PHASE_W:0]   phase_sum, phase_left;
    logic [PHASE_W-1:0] phase_sat;

    // Ring offset from the read pointer; the offset never reaches two depths.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [MW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(FIFO_DEPTH))
            s = s - SW'(FIFO_DEPTH);
        return s[ADDR_W-1:0];
    endfunction

    assign in_ch.ready = !s1_valid_reg || q_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign active      = cfg.enabled && !cfg.paused;

    assign pos_x     = MW'(phase_reg[PHASE_W-1:FRAC_W]);
    assign count_x   = MW'(count_reg);
    assign under_hit = pos_x >= count_x;
    assign nxt_x     = (pos_x + MW'(1) < count_x) ? pos_x + MW'(1) : pos_x;

    assign addr_a = wrap_add(rp_reg, pos_x);
    assign addr_b = wrap_add(rp_reg, nxt_x);
    assign slot   = wrap_add(rp_reg, count_x);

    // Phase advance: whole frames passed over are popped, limited to what is queued.
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, cfg.step_ratio};
    assign whole_x    = MW'(phase_sum[PHASE_W:FRAC_W]);
    assign used_x     = (whole_x > count_x) ? count_x : whole_x;
    assign phase_left = phase_sum - {used_x[WHOLE_W-1:0], {FRAC_W{1'b0}}};
    assign phase_sat  = phase_left[PHASE_W] ? {PHASE_W{1'b1}} : phase_left[PHASE_W-1:0];

    always_comb
    begin
        rp_next    = rp_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        under_next = under_reg;
        tick_next  = tick_reg;
        push_next  = push_reg;
        push_ok    = 1'b0;

        info_next          = '0;
        info_next.frac     = phase_reg[FRAC_W-1:0];

        unique case (cmd_t'(in_ch.cmd))
            CMD_PUSH:
            begin
                push_ok = cfg.enabled && (count_x < MW'(FIFO_DEPTH));
                if (push_ok)
                begin
                    count_next         = count_reg + CNT_W'(1);
                    push_next          = push_reg + PCNT_W'(1);
                    info_next.accepted = 1'b1;
                end
            end
            CMD_MIX:
            begin
                info_next.mix_l = in_ch.mix_in_left;
                info_next.mix_r = in_ch.mix_in_right;
                if (active)
                begin
                    tick_next = tick_reg + TCNT_W'(1);
                    if (under_hit)
                    begin
                        under_next         = under_reg + UCNT_W'(1);
                        info_next.underrun = 1'b1;
                    end
                    else
                    begin
                        info_next.lerp = 1'b1;
                        rp_next        = wrap_add(rp_reg, used_x);
                        count_next     = count_reg - used_x[CNT_W-1:0];
                        phase_next     = phase_sat;
                    end
                end
            end
            CMD_FLUSH:
            begin
                rp_next    = '0;
                count_next = '0;
                phase_next = '0;
            end
            CMD_NOP:
            begin
                rp_next = rp_reg;
            end
        endcase

        info_next.queued_count   = QCNT_W'(count_next);
        info_next.underrun_total = under_next;
        info_next.ticks_total    = tick_next;
        info_next.pushed_total   = push_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg       <= '0;
            count_reg    <= '0;
            phase_reg    <= '0;
            under_reg    <= '0;
            tick_reg     <= '0;
            push_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rp_reg    <= rp_next;
                count_reg <= count_next;
                phase_reg <= phase_next;
                under_reg <= under_next;
                tick_reg  <= tick_next;
                push_reg  <= push_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (q_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    // Ring and its two read ports; read data is held until the next interpolated mix.
    always_ff @(posedge clk)
    begin
        if (accept && push_ok)
            frame_ring[slot] <= {in_ch.push_right, in_ch.push_left};
        if (accept && info_next.lerp)
        begin
            frame_a_reg <= frame_ring[addr_a];
            frame_b_reg <= frame_ring[addr_b];
        end
        if (accept)
            info_reg <= info_next;
    end

    assign q_valid        = s1_valid_reg;
    assign q_data.info    = info_reg;
    assign q_data.frame_a = frame_a_reg;
    assign q_data.frame_b = frame_b_reg;

endmodule

// ===== rtl/sflr_queue.sv =====
`timescale 1ns / 1ps

module sflr_queue import sflr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  rec_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output rec_t rd_data
);

    rec_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg, fill_next;
    logic               do_wr, do_rd;

    assign wr_ready = fill_reg != QFILL_W'(QUEUE_DEPTH);
    assign rd_valid = fill_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_data  = slots[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_wr && !do_rd)
            fill_next = fill_reg + QFILL_W'(1);
        else if (do_rd && !do_wr)
            fill_next = fill_reg - QFILL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/sflr_back.sv =====
`timescale 1ns / 1ps

module sflr_back import sflr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  rec_t       q_data,
    sflr_out_if.source out_ch
);

    typedef struct packed {
        info_t                      info;
        logic signed [SAMPLE_W-1:0] base_l;
        logic signed [SAMPLE_W-1:0] base_r;
        logic signed [PROD_W-1:0]   prod_l;
        logic signed [PROD_W-1:0]   prod_r;
    } mul_t;

    typedef struct packed {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic                       underrun;
        logic [QCNT_W-1:0]          queued_count;
        logic [UCNT_W-1:0]          underrun_total;
        logic [TCNT_W-1:0]          ticks_total;
        logic [PCNT_W-1:0]          pushed_total;
    } res_t;

    mul_t  mul_reg, mul_next;
    res_t  res_reg, res_next;
    logic  mul_valid_reg, out_valid_reg;
    logic  pop, out_adv;

    logic signed [SAMPLE_W-1:0] a_l, a_r, b_l, b_r;
    logic signed [SAMPLE_W:0]   diff_l, diff_r, frac_s;

    // Rounds the product to Q1.15, adds base and mix input, and saturates.
    function automatic logic signed [SAMPLE_W-1:0] mix_sat(
        input logic signed [SAMPLE_W-1:0] base,
        input logic signed [PROD_W-1:0]   prod,
        input logic signed [SAMPLE_W-1:0] mix
    );
        logic signed [PROD_W-1:0] rnd;
        logic signed [19:0]       sum;
        rnd = prod + PROD_W'(32768);
        sum = 20'($signed(rnd[PROD_W-1:FRAC_W])) + 20'(base) + 20'(mix);
        if (sum > 20'sd32767)
            return 16'sh7FFF;
        else if (sum < -20'sd32768)
            return 16'sh8000;
        else
            return sum[SAMPLE_W-1:0];
    endfunction

    assign out_adv = !out_valid_reg || out_ch.ready;
    assign q_ready = !mul_valid_reg || out_adv;
    assign pop     = q_valid && q_ready;

    assign a_l    = $signed(q_data.frame_a[SAMPLE_W-1:0]);
    assign a_r    = $signed(q_data.frame_a[FRAME_W-1:SAMPLE_W]);
    assign b_l    = $signed(q_data.frame_b[SAMPLE_W-1:0]);
    assign b_r    = $signed(q_data.frame_b[FRAME_W-1:SAMPLE_W]);
    assign diff_l = (SAMPLE_W+1)'(b_l) - (SAMPLE_W+1)'(a_l);
    assign diff_r = (SAMPLE_W+1)'(b_r) - (SAMPLE_W+1)'(a_r);
    assign frac_s = $signed({1'b0, q_data.info.frac});

    always_comb
    begin
        mul_next.info   = q_data.info;
        mul_next.base_l = a_l;
        mul_next.base_r = a_r;
        mul_next.prod_l = PROD_W'(diff_l) * PROD_W'(frac_s);
        mul_next.prod_r = PROD_W'(diff_r) * PROD_W'(frac_s);
    end

    always_comb
    begin
        res_next.accepted       = mul_reg.info.accepted;
        res_next.underrun       = mul_reg.info.underrun;
        res_next.queued_count   = mul_reg.info.queued_count;
        res_next.underrun_total = mul_reg.info.underrun_total;
        res_next.ticks_total    = mul_reg.info.ticks_total;
        res_next.pushed_total   = mul_reg.info.pushed_total;
        if (mul_reg.info.lerp)
        begin
            res_next.mixed_left  = mix_sat(mul_reg.base_l, mul_reg.prod_l,
                                           $signed(mul_reg.info.mix_l));
            res_next.mixed_right = mix_sat(mul_reg.base_r, mul_reg.prod_r,
                                           $signed(mul_reg.info.mix_r));
        end
        else
        begin
            res_next.mixed_left  = mul_reg.info.mix_l;
            res_next.mixed_right = mul_reg.info.mix_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_ready)
                mul_valid_reg <= q_valid;
            if (out_adv)
                out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            mul_reg <= mul_next;
        if (out_adv && mul_valid_reg)
            res_reg <= res_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.accepted       = res_reg.accepted;
    assign out_ch.mixed_left     = res_reg.mixed_left;
    assign out_ch.mixed_right    = res_reg.mixed_right;
    assign out_ch.underrun       = res_reg.underrun;
    assign out_ch.queued_count   = res_reg.queued_count;
    assign out_ch.underrun_total = res_reg.underrun_total;
    assign out_ch.ticks_total    = res_reg.ticks_total;
    assign out_ch.pushed_total   = res_reg.pushed_total;

endmodule

// ===== rtl/stereo_fifo_linear_resampler.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Handshake        Contents
// in_ch      sink       valid / ready    cmd, push frame, mix inputs
// out_ch     source     valid / ready    accepted, mixed frame, underrun, fill, counters
// APB        slave      psel / penable   enabled (0x0), paused (0x4), step_ratio (0x8)
//
// One word is taken every cycle while the queue has room; the ring pointers, fill and
// phase update in the cycle a word is accepted, so mixes and pushes follow back to back.
// A result passes the front register, then the queue, multiply and round registers.
// The ring has no clearing pass after reset; only entries written by pushes are read.
// A four-entry queue lets the front keep taking words while the output is stalled.

module stereo_fifo_linear_resampler import sflr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    sflr_in_if.sink               in_ch,
    sflr_out_if.source            out_ch
);

    cfg_t cfg;
    logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    rec_t q_wr_data, q_rd_data;

    sflr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sflr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_ch   (in_ch),
        .q_valid (q_wr_valid),
        .q_ready (q_wr_ready),
        .q_data  (q_wr_data)
    );

    sflr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    sflr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_rd_valid),
        .q_ready (q_rd_ready),
        .q_data  (q_rd_data),
        .out_ch  (out_ch)
    );

    // The front refuses a word only when its staged word cannot move into a full queue.
    a_front_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (q_wr_valid && !q_wr_ready))
        else $error("input stalled while the queue had room");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.queued_count <= QCNT_W'(FIFO_DEPTH)))
        else $error("reported fill exceeds ring depth");

    a_push_mix_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.accepted && out_ch.underrun))
        else $error("result flags both a stored push and an underrun");

    a_queue_drains_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        (q_rd_valid && !q_rd_ready) |-> (out_ch.valid && !out_ch.ready))
        else $error("back end held off the queue without an output stall");

endmodule

// ===== bench/tb_stereo_fifo_linear_resampler.sv =====
`timescale 1ns / 1ps

module tb_stereo_fifo_linear_resampler;
    import sflr_pkg::*;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [SAMPLE_W-1:0] push_left;
        logic signed [SAMPLE_W-1:0] push_right;
        logic signed [SAMPLE_W-1:0] mix_in_left;
        logic signed [SAMPLE_W-1:0] mix_in_right;
    } word_t;

    typedef struct packed {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] mixed_left;
        logic signed [SAMPLE_W-1:0] mixed_right;
        logic                       underrun;
        logic [QCNT_W-1:0]          queued_count;
        logic [UCNT_W-1:0]          underrun_total;
        logic [TCNT_W-1:0]          ticks_total;
        logic [PCNT_W-1:0]          pushed_total;
    } frame_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sflr_in_if  in_ch ();
    sflr_out_if out_ch ();

    stereo_fifo_linear_resampler i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Shadow of the block's state and registers.
    logic [FRAME_W-1:0] frame_store [FIFO_DEPTH];
    int unsigned        rd_ptr;
    int unsigned        held;
    logic [PHASE_W-1:0] phase_acc;
    logic [UCNT_W-1:0]  underrun_count;
    logic [TCNT_W-1:0]  tick_count;
    logic [PCNT_W-1:0]  pushes_seen;
    cfg_t               model_cfg;

    word_t         pending_words[$];
    frame_result_t predicted_frames[$];
    word_t         offered;

    int  failures  = 0;
    int  n_words   = 0;
    int  n_refused = 0;
    int  n_lerp    = 0;
    int  n_under   = 0;
    int  n_clipped = 0;
    int  n_configs = 0;
    bit  calm      = 1'b0;
    bit  hold_arm  = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [SAMPLE_W-1:0] blend_onto(
        logic signed [SAMPLE_W-1:0] base,
        logic signed [SAMPLE_W-1:0] near,
        logic signed [SAMPLE_W-1:0] far,
        logic [FRAC_W-1:0]          frac
    );
        longint lerp_term;
        longint total;
        lerp_term = (longint'(far) - longint'(near)) * longint'(frac) + 64'sd32768;
        // Arithmetic shift of the signed product floors toward minus infinity.
        total = longint'(base) + longint'(near) + (lerp_term >>> FRAC_W);
        if (total > 32767)
        begin
            n_clipped++;
            return 16'sh7FFF;
        end
        if (total < -32768)
        begin
            n_clipped++;
            return 16'sh8000;
        end
        return total[SAMPLE_W-1:0];
    endfunction

    function automatic frame_result_t resample_word(word_t w);
        frame_result_t      r;
        int unsigned        pos;
        int unsigned        nxt;
        int unsigned        sum;
        int unsigned        used;
        logic [FRAME_W-1:0] near_f;
        logic [FRAME_W-1:0] far_f;
        r = '0;
        n_words++;
        case (w.cmd)
            CMD_PUSH:
            begin
                if (model_cfg.enabled && held < FIFO_DEPTH)
                begin
                    frame_store[ADDR_W'((rd_ptr + held) % FIFO_DEPTH)] =
                        {w.push_right, w.push_left};
                    held++;
                    pushes_seen = pushes_seen + PCNT_W'(1);
                    r.accepted = 1'b1;
                end
                else
                    n_refused++;
            end
            CMD_MIX:
            begin
                r.mixed_left  = w.mix_in_left;
                r.mixed_right = w.mix_in_right;
                if (model_cfg.enabled && !model_cfg.paused)
                begin
                    pos = 32'(phase_acc[PHASE_W-1:FRAC_W]);
                    tick_count = tick_count + TCNT_W'(1);
                    if (pos >= held)
                    begin
                        r.underrun = 1'b1;
                        underrun_count = underrun_count + UCNT_W'(1);
                        n_under++;
                    end
                    else
                    begin
                        // The neighbor is clamped to the last queued frame.
                        nxt = (pos + 1 < held) ? pos + 1 : pos;
                        near_f = frame_store[ADDR_W'((rd_ptr + pos) % FIFO_DEPTH)];
                        far_f  = frame_store[ADDR_W'((rd_ptr + nxt) % FIFO_DEPTH)];
                        r.mixed_left = blend_onto(w.mix_in_left, near_f[SAMPLE_W-1:0],
                                                  far_f[SAMPLE_W-1:0], phase_acc[FRAC_W-1:0]);
                        r.mixed_right = blend_onto(w.mix_in_right, near_f[FRAME_W-1:SAMPLE_W],
                                                   far_f[FRAME_W-1:SAMPLE_W],
                                                   phase_acc[FRAC_W-1:0]);
                        n_lerp++;
                        sum = 32'(phase_acc);
                        sum += 32'(model_cfg.step_ratio);
                        used = sum >> FRAC_W;
                        if (used > held)
                            used = held;
                        rd_ptr = (rd_ptr + used) % FIFO_DEPTH;
                        held -= used;
                        sum -= used << FRAC_W;
                        phase_acc = (sum > 32'hFFFFFF) ? 24'hFFFFFF : sum[PHASE_W-1:0];
                    end
                end
            end
            CMD_FLUSH:
            begin
                rd_ptr    = 0;
                held      = 0;
                phase_acc = '0;
            end
            default: ;
        endcase
        r.queued_count   = held[QCNT_W-1:0];
        r.underrun_total = underrun_count;
        r.ticks_total    = tick_count;
        r.pushed_total   = pushes_seen;
        return r;
    endfunction

    function automatic word_t word_of(cmd_t c, int pl, int pr, int ml, int mr);
        word_t w;
        w.cmd          = c;
        w.push_left    = pl[SAMPLE_W-1:0];
        w.push_right   = pr[SAMPLE_W-1:0];
        w.mix_in_left  = ml[SAMPLE_W-1:0];
        w.mix_in_right = mr[SAMPLE_W-1:0];
        return w;
    endfunction

    function automatic int rand_sample();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 32767 : -32768;
        return $urandom_range(65535) - 32768;
    endfunction

    function automatic word_t random_word(int push_pct);
        int   roll;
        cmd_t c;
        roll = $urandom_range(99);
        if (roll < push_pct)
            c = CMD_PUSH;
        else if (roll < push_pct + 42)
            c = CMD_MIX;
        else if (roll < push_pct + 46)
            c = CMD_FLUSH;
        else
            c = CMD_NOP;
        return word_of(c, rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endfunction

    function automatic void compare_field(string name, logic [PCNT_W-1:0] want,
                                          logic [PCNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The write lands at this edge; turn straight into a read of the same register.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        compare_field("prdata", PCNT_W'(value), PCNT_W'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ENABLED: model_cfg.enabled    = value[0];
            REG_PAUSED:  model_cfg.paused     = value[0];
            REG_STEP:    model_cfg.step_ratio = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_ch.valid || predicted_frames.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic settle_and_configure(bit en, bit pa, logic [STEP_W-1:0] step);
        wait_idle();
        write_reg(REG_ENABLED, APB_DATA_W'(en));
        write_reg(REG_PAUSED, APB_DATA_W'(pa));
        write_reg(REG_STEP, APB_DATA_W'(step));
        n_configs++;
        @(negedge clk);
    endtask

    // Sender: offers queued words, idling now and then.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.cmd          <= CMD_NOP;
            in_ch.push_left    <= '0;
            in_ch.push_right   <= '0;
            in_ch.mix_in_left  <= '0;
            in_ch.mix_in_right <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predicted_frames.push_back(resample_word(offered));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 13))
                begin
                    offered = pending_words.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.cmd          <= offered.cmd;
                    in_ch.push_left    <= offered.push_left;
                    in_ch.push_right   <= offered.push_right;
                    in_ch.mix_in_left  <= offered.mix_in_left;
                    in_ch.mix_in_right <= offered.mix_in_right;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with one long hold-off when armed.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (hold_arm && !hold_done)
            begin
                hold_done    <= 1'b1;
                hold_left    <= 400;
                out_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= calm || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (predicted_frames.size() == 0)
            begin
                $error("result word arrived with no prediction waiting");
                failures++;
            end
            else
            begin
                want = predicted_frames.pop_front();
                compare_field("accepted", PCNT_W'(want.accepted), PCNT_W'(out_ch.accepted));
                compare_field("mixed_left", PCNT_W'(want.mixed_left),
                              PCNT_W'(out_ch.mixed_left));
                compare_field("mixed_right", PCNT_W'(want.mixed_right),
                              PCNT_W'(out_ch.mixed_right));
                compare_field("underrun", PCNT_W'(want.underrun), PCNT_W'(out_ch.underrun));
                compare_field("queued_count", PCNT_W'(want.queued_count),
                              PCNT_W'(out_ch.queued_count));
                compare_field("underrun_total", PCNT_W'(want.underrun_total),
                              PCNT_W'(out_ch.underrun_total));
                compare_field("ticks_total", PCNT_W'(want.ticks_total),
                              PCNT_W'(out_ch.ticks_total));
                compare_field("pushed_total", want.pushed_total, out_ch.pushed_total);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_stereo_fifo_linear_resampler: errors");
        $finish;
    end

    initial
    begin
        bit               en;
        bit               pa;
        logic [STEP_W-1:0] step;
        int               push_pct;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;

        rd_ptr             = 0;
        held               = 0;
        phase_acc          = '0;
        underrun_count     = '0;
        tick_count         = '0;
        pushes_seen        = '0;
        model_cfg.enabled    = 1'b0;
        model_cfg.paused     = 1'b1;
        model_cfg.step_ratio = STEP_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: disabled, so pushes are refused and mixes pass through.
        pending_words.push_back(word_of(CMD_PUSH, 32767, -32768, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 32767, -32768));
        pending_words.push_back(word_of(CMD_FLUSH, -1, -1, -1, -1));
        pending_words.push_back(word_of(CMD_NOP, rand_sample(), rand_sample(),
                                        rand_sample(), rand_sample()));

        // Enabled but paused: frames queue, mixes still pass through.
        settle_and_configure(1'b1, 1'b1, STEP_RESET);
        pending_words.push_back(word_of(CMD_PUSH, 32767, -32768, 0, 0));
        pending_words.push_back(word_of(CMD_PUSH, -32768, 32767, 0, 0));
        pending_words.push_back(word_of(CMD_PUSH, 0, -1, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 1234, -1234));

        // Half step over extreme frames: rounding, clipping, clamped neighbor, underrun.
        settle_and_configure(1'b1, 1'b0, 24'h008000);
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 32767, -32768));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, -32768, 32767));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 32767, 32767));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, -32768, -32768));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 100, -100));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 5, 6));
        pending_words.push_back(word_of(CMD_PUSH, 100, -100, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 7, 8));
        pending_words.push_back(word_of(CMD_FLUSH, 0, 0, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, -9, 9));

        // Zero step replays the same position.
        settle_and_configure(1'b1, 1'b0, 24'h000000);
        pending_words.push_back(word_of(CMD_PUSH, -20000, 20000, 0, 0));
        pending_words.push_back(word_of(CMD_PUSH, 30000, -30000, 0, 0));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, 15000, -15000));
        pending_words.push_back(word_of(CMD_MIX, 0, 0, -15000, 15000));

        // Queue a burst, then drain at the largest step so one tick empties the ring.
        settle_and_configure(1'b1, 1'b0, 24'hFFFFFF);
        pending_words.push_back(word_of(CMD_FLUSH, 0, 0, 0, 0));
        repeat (40)
            pending_words.push_back(word_of(CMD_PUSH, rand_sample(), rand_sample(), 0, 0));
        repeat (12)
            pending_words.push_back(word_of(CMD_MIX, 0, 0, rand_sample(), rand_sample()));
        repeat (8)
            pending_words.push_back(word_of(CMD_PUSH, rand_sample(), rand_sample(), 0, 0));

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin en = 1'b1; pa = 1'b0; step = 24'h010000; end
                1: begin en = 1'b1; pa = 1'b0;
                         step = STEP_W'($urandom_range(24'h2FFFF, 24'h00800)); end
                2: begin en = 1'b1; pa = 1'b0; step = 24'h000001; end
                3: begin en = 1'b1; pa = 1'b0; step = 24'hFFFFFF; end
                4: begin en = 1'b0; pa = 1'b0;
                         step = STEP_W'($urandom_range(24'hFFFFFF, 1)); end
                5: begin en = 1'b1; pa = 1'b1;
                         step = STEP_W'($urandom_range(24'hFFFFFF, 1)); end
                6: begin en = 1'b1; pa = 1'b0; step = 24'h000000; end
                default: begin en = 1'b1; pa = 1'b0;
                               step = STEP_W'($urandom_range(24'h3FFFF, 1)); end
            endcase
            settle_and_configure(en, pa, step);
            calm = (ph == 0);
            // The receiver stalls for a long stretch while words keep coming.
            if (ph == 2)
                hold_arm = 1'b1;
            push_pct = (step > 24'h010000) ? 55 : ((step < 24'h010000) ? 35 : 45);
            repeat (90)
                pending_words.push_back(random_word(push_pct));
        end

        wait_idle();
        $display("covered %0d words over %0d register settings: %0d refused pushes,",
                 n_words, n_configs + 1, n_refused);
        $display("%0d interpolated ticks, %0d underrun ticks, %0d clipped samples",
                 n_lerp, n_under, n_clipped);
        if (failures == 0)
            $display("tb_stereo_fifo_linear_resampler: clean");
        else
            $display("tb_stereo_fifo_linear_resampler: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sflr_pkg.sv
rtl/sflr_if.sv
rtl/sflr_cfg.sv
rtl/sflr_front.sv
rtl/sflr_queue.sv
rtl/sflr_back.sv
rtl/stereo_fifo_linear_resampler.sv
bench/tb_stereo_fifo_linear_resampler.sv
